// ===== design/aef_pkg.sv =====
// ----------------------------------------------------------------------------
// aef_pkg
// Shared types, constants and helpers for the ANSI escape fixup block.
// ----------------------------------------------------------------------------
package aef_pkg;

    // Session count and state memory geometry
    localparam int SESSIONS = 4;
    localparam int SESS_AW  = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int ST_W     = 3;
    localparam int PLEN_W   = 3;
    localparam int CNT_W    = 4;

    typedef logic [ST_W-1:0]    t_state;
    typedef logic [SESS_AW-1:0] t_addr;

    // Matcher states
    localparam t_state ST_IDLE  = 3'd0;  // nothing held
    localparam t_state ST_ESC   = 3'd1;  // ESC
    localparam t_state ST_CSI   = 3'd2;  // ESC [
    localparam t_state ST_Q     = 3'd3;  // ESC [ ?
    localparam t_state ST_Q2    = 3'd4;  // ESC [ ? 2
    localparam t_state ST_Q20   = 3'd5;  // ESC [ ? 2 0
    localparam t_state ST_Q202  = 3'd6;  // ESC [ ? 2 0 2
    localparam t_state ST_Q2026 = 3'd7;  // ESC [ ? 2 0 2 6

    // Characters of interest
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
    localparam logic [7:0] CH_SAVE   = 8'h73;  // s
    localparam logic [7:0] CH_REST   = 8'h75;  // u
    localparam logic [7:0] CH_QUEST  = 8'h3F;  // ?
    localparam logic [7:0] CH_TWO    = 8'h32;  // 2
    localparam logic [7:0] CH_ZERO   = 8'h30;  // 0
    localparam logic [7:0] CH_SIX    = 8'h36;  // 6
    localparam logic [7:0] CH_SET    = 8'h68;  // h
    localparam logic [7:0] CH_RESET  = 8'h6C;  // l
    localparam logic [7:0] CH_SEVEN  = 8'h37;  // 7
    localparam logic [7:0] CH_EIGHT  = 8'h38;  // 8

    // Output job: replay first plen bytes of the held prefix, then tail
    typedef struct packed {
        logic [PLEN_W-1:0] plen;
        logic              has_tail;
        logic [7:0]        tail;
    } t_desc;

    // Byte idx of the held prefix ESC [ ? 2 0 2 6
    function automatic logic [7:0] prefix_byte(input logic [PLEN_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = CH_ESC;
            3'd1:    b = CH_LBRACK;
            3'd2:    b = CH_QUEST;
            3'd3:    b = CH_TWO;
            3'd4:    b = CH_ZERO;
            3'd5:    b = CH_TWO;
            3'd6:    b = CH_SIX;
            default: b = CH_ESC;
        endcase
        return b;
    endfunction

endpackage

// ===== design/aef_if.sv =====
// ----------------------------------------------------------------------------
// aef_in_if / aef_out_if
// Valid/ready channels carrying input bytes and translated output bytes.
// ----------------------------------------------------------------------------
interface aef_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] session;
    logic [7:0] in_byte;
    logic       end_of_chunk;

    modport source (output valid, session, in_byte, end_of_chunk, input ready);
    modport sink   (input valid, session, in_byte, end_of_chunk, output ready);
endinterface

interface aef_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] out_session;

    modport source (output valid, out_byte, last, out_session, input ready);
    modport sink   (input valid, out_byte, last, out_session, output ready);
endinterface

// ===== design/aef_ram.sv =====
// ----------------------------------------------------------------------------
// aef_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address write; holds when idle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== design/aef_match.sv =====
// ----------------------------------------------------------------------------
// aef_match
// Matcher step: from the current state and byte, the next state and the
// bytes to replay.
// ----------------------------------------------------------------------------
module aef_match
    import aef_pkg::*;
(
    input  logic       i_in_range,
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    output t_state     o_next,
    output t_desc      o_desc
);

    // Decode one byte against the session's partial match
    always_comb begin
        o_next = ST_IDLE;
        o_desc = '{plen: 3'd0, has_tail: 1'b1, tail: i_byte};
        if (i_in_range) begin
            unique case (i_state)
                ST_IDLE: begin
                    if (i_byte == CH_ESC) begin
                        o_next          = ST_ESC;
                        o_desc.has_tail = 1'b0;
                    end
                end
                ST_ESC: begin
                    if (i_byte == CH_LBRACK) begin
                        o_next          = ST_CSI;
                        o_desc.has_tail = 1'b0;
                    end else if (i_byte == CH_ESC) begin
                        // lone ESC replayed, new match starts
                        o_next          = ST_ESC;
                        o_desc.plen     = 3'd1;
                        o_desc.has_tail = 1'b0;
                    end else begin
                        o_desc.plen = 3'd1;
                    end
                end
                ST_CSI: begin
                    if (i_byte == CH_SAVE) begin
                        o_desc.plen = 3'd1;
                        o_desc.tail = CH_SEVEN;
                    end else if (i_byte == CH_REST) begin
                        o_desc.plen = 3'd1;
                        o_desc.tail = CH_EIGHT;
                    end else if (i_byte == CH_QUEST) begin
                        o_next          = ST_Q;
                        o_desc.has_tail = 1'b0;
                    end else begin
                        o_desc.plen = 3'd2;
                    end
                end
                ST_Q, ST_Q2, ST_Q20, ST_Q202: begin
                    if (i_byte == prefix_byte(i_state)) begin
                        o_next          = i_state + 3'd1;
                        o_desc.has_tail = 1'b0;
                    end else begin
                        o_desc.plen = i_state;
                    end
                end
                ST_Q2026: begin
                    if (i_byte == CH_SET || i_byte == CH_RESET) begin
                        o_desc.has_tail = 1'b0;
                    end else begin
                        o_desc.plen = 3'd7;
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/aef_emit.sv =====
// ----------------------------------------------------------------------------
// aef_emit
// Output sequencer: plays out one job of up to eight bytes, one per transfer.
// ----------------------------------------------------------------------------
module aef_emit
    import aef_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_desc      i_desc,
    input  logic [1:0] i_session,
    output logic       o_free,
    aef_out_if.source  o_out
);

    logic              r_valid;
    t_desc             r_desc;
    logic [1:0]        r_sess;
    logic [PLEN_W-1:0] r_idx;
    logic [CNT_W-1:0]  w_total;
    logic              w_last;
    logic              w_xfer;

    // Position within the job
    assign w_total = CNT_W'(r_desc.plen) + CNT_W'(r_desc.has_tail);
    assign w_last  = (CNT_W'(r_idx) + CNT_W'(1)) == w_total;
    assign w_xfer  = r_valid && o_out.ready;
    assign o_free  = !r_valid || (w_xfer && w_last);

    // Drive the channel
    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = (r_idx < r_desc.plen) ? prefix_byte(r_idx) : r_desc.tail;
    assign o_out.last        = w_last;
    assign o_out.out_session = r_sess;

    // Control: load a job or advance one byte per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_desc <= i_desc;
            r_sess <= i_session;
            r_idx  <= '0;
        end else if (w_xfer) begin
            r_idx  <= r_idx + PLEN_W'(1);
        end
    end

endmodule

// ===== design/ansi_escape_fixup.sv =====
// ----------------------------------------------------------------------------
// ansi_escape_fixup
// Per-session terminal escape rewriter: ESC [ s -> ESC 7, ESC [ u -> ESC 8,
// ESC [ ? 2 0 2 6 h/l removed, failed partial matches replayed.
// ----------------------------------------------------------------------------
// Each input byte is read against its session's matcher state, kept in a
// small RAM: the state is read in the cycle of the input transfer, decoded
// in the next cycle and written back when the decode stage advances, with
// the new state forwarded when the following byte belongs to the same
// session. Bytes that yield zero or one output byte stream at one per clock
// while the output is ready; a byte that yields more (up to eight) holds the
// output sequencer until all are transferred, during which input stalls once
// the decode stage is full. Each input byte is registered into the decode
// stage and its output bytes into the output sequencer. All sessions start idle after reset.
// ----------------------------------------------------------------------------
module ansi_escape_fixup
    import aef_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    aef_in_if.sink    i_in,
    aef_out_if.source o_out
);

    logic          w_in_xfer;
    logic          w_rd_range;
    t_addr         w_raddr;
    t_state        w_rdata;

    logic          r_ex_valid;
    logic [1:0]    r_ex_sess;
    logic [7:0]    r_ex_byte;
    logic          r_ex_range;
    logic          r_ex_vbit;
    logic          r_ex_fwd;
    t_state        r_ex_fwd_st;
    t_addr         w_ex_addr;
    t_state        w_ex_state;
    t_state        w_ex_next;
    t_desc         w_ex_desc;
    logic          w_ex_emit;
    logic          w_ex_adv;
    logic          w_we;
    logic          w_em_free;

    logic [SESSIONS-1:0] r_sv;

    // Input side
    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_raddr    = SESS_AW'(i_in.session);
    assign w_rd_range = (32'(i_in.session) < SESSIONS);
    assign i_in.ready = !r_ex_valid || w_ex_adv;

    // Decode stage
    assign w_ex_addr  = SESS_AW'(r_ex_sess);
    assign w_ex_state = r_ex_fwd ? r_ex_fwd_st : (r_ex_vbit ? w_rdata : ST_IDLE);
    assign w_ex_emit  = (w_ex_desc.plen != '0) || w_ex_desc.has_tail;
    assign w_ex_adv   = r_ex_valid && (!w_ex_emit || w_em_free);
    assign w_we       = w_ex_adv && r_ex_range;

    aef_ram #(
        .WIDTH (ST_W),
        .DEPTH (SESSIONS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_ex_addr),
        .i_wdata (w_ex_next),
        .i_re    (w_in_xfer),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    aef_match u_match (
        .i_in_range (r_ex_range),
        .i_state    (w_ex_state),
        .i_byte     (r_ex_byte),
        .o_next     (w_ex_next),
        .o_desc     (w_ex_desc)
    );

    aef_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (r_ex_valid && w_ex_emit),
        .i_desc    (w_ex_desc),
        .i_session (r_ex_sess),
        .o_free    (w_em_free),
        .o_out     (o_out)
    );

    // Hold decode stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_ex_valid <= i_in.valid;
        end
    end

    // Capture the item; forward a same-session write that lands with the read
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_ex_sess   <= i_in.session;
            r_ex_byte   <= i_in.in_byte;
            r_ex_range  <= w_rd_range;
            r_ex_vbit   <= w_rd_range && r_sv[w_raddr];
            r_ex_fwd    <= w_we && (r_ex_sess == i_in.session);
            r_ex_fwd_st <= w_ex_next;
        end
    end

    // Mark entries written since reset; unwritten ones read as idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else if (w_we) begin
            r_sv[w_ex_addr] <= 1'b1;
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ansi_escape_fixup. Drives session-tagged bytes
// through the input channel, predicts the rewritten byte stream per session
// in a scoreboard, and checks every output transfer against it in order.
// ----------------------------------------------------------------------------
module tb;
    import aef_pkg::*;

    // One expected output transfer
    typedef struct {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] out_session;
    } t_out_rec;

    // Tracks the matcher of every session and holds the bytes still owed
    class rewrite_scoreboard;
        t_out_rec   pending[$];
        t_state     match_st[SESSIONS];
        logic [7:0] held_prefix[7];
        int         errors;

        function new();
            foreach (match_st[i]) match_st[i] = ST_IDLE;
            held_prefix = '{CH_ESC, CH_LBRACK, CH_QUEST, CH_TWO, CH_ZERO, CH_TWO, CH_SIX};
            errors = 0;
        endfunction

        function void owe_byte(logic [7:0] b, logic [1:0] s);
            t_out_rec r;
            r.out_byte    = b;
            r.last        = 1'b0;
            r.out_session = s;
            pending.push_back(r);
        endfunction

        function void owe_prefix(int len, logic [1:0] s);
            for (int i = 0; i < len && i < 7; i++) owe_byte(held_prefix[i], s);
        endfunction

        // Advance the session matcher on an accepted byte
        function void note_accepted_byte(logic [1:0] s, logic [7:0] c);
            int     first;
            t_state st;
            first = pending.size();
            if (s >= SESSIONS) begin
                owe_byte(c, s);
            end else begin
                st = match_st[s];
                case (st)
                    ST_IDLE: begin
                        if (c == CH_ESC) st = ST_ESC;
                        else owe_byte(c, s);
                    end
                    ST_ESC: begin
                        if (c == CH_LBRACK) begin
                            st = ST_CSI;
                        end else begin
                            owe_byte(CH_ESC, s);
                            // re-examine the byte from idle
                            if (c == CH_ESC) begin
                                st = ST_ESC;
                            end else begin
                                st = ST_IDLE;
                                owe_byte(c, s);
                            end
                        end
                    end
                    ST_CSI: begin
                        if (c == CH_SAVE) begin
                            owe_byte(CH_ESC, s);
                            owe_byte(CH_SEVEN, s);
                            st = ST_IDLE;
                        end else if (c == CH_REST) begin
                            owe_byte(CH_ESC, s);
                            owe_byte(CH_EIGHT, s);
                            st = ST_IDLE;
                        end else if (c == CH_QUEST) begin
                            st = ST_Q;
                        end else begin
                            owe_prefix(2, s);
                            owe_byte(c, s);
                            st = ST_IDLE;
                        end
                    end
                    ST_Q, ST_Q2, ST_Q20, ST_Q202: begin
                        if (c == held_prefix[st]) begin
                            st = st + 1'b1;
                        end else begin
                            owe_prefix(int'(st), s);
                            owe_byte(c, s);
                            st = ST_IDLE;
                        end
                    end
                    default: begin
                        // h or l drop the whole sequence
                        if (c != CH_SET && c != CH_RESET) begin
                            owe_prefix(7, s);
                            owe_byte(c, s);
                        end
                        st = ST_IDLE;
                    end
                endcase
                match_st[s] = st;
            end
            if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
        endfunction

        // Compare one output transfer with the oldest owed byte
        function void check_out_byte(logic [7:0] b, logic l, logic [1:0] s);
            t_out_rec r;
            if (pending.size() == 0) begin
                $error("unexpected output byte %h (last %b, session %0d)", b, l, s);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (b !== r.out_byte) begin
                $error("out_byte mismatch: expected %h, actual %h", r.out_byte, b);
                errors++;
            end
            if (l !== r.last) begin
                $error("last mismatch: expected %b, actual %b", r.last, l);
                errors++;
            end
            if (s !== r.out_session) begin
                $error("out_session mismatch: expected %0d, actual %0d", r.out_session, s);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    aef_in_if  in_ch ();
    aef_out_if out_ch ();

    ansi_escape_fixup u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rewrite_scoreboard sb = new();

    bit idle_enable   = 1'b1;
    int hold_requests = 0;
    int sent_count    = 0;

    // Generate the clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watch both channels for transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_accepted_byte(in_ch.session, in_ch.in_byte);
            if (out_ch.valid && out_ch.ready)
                sb.check_out_byte(out_ch.out_byte, out_ch.last, out_ch.out_session);
        end
    end

    // Drive output ready: random idling, plus long hold-offs on request
    initial begin
        int hold_left;
        int hold_served;
        hold_left    = 0;
        hold_served  = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_requests != hold_served) begin
                hold_served++;
                hold_left = 79;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(idle_enable && $urandom_range(0, 99) < 7);
            end
        end
    end

    // Offer one byte and hold it until the transfer
    task automatic send_byte(input logic [1:0] s, input logic [7:0] b);
        @(negedge i_clk);
        while (idle_enable && $urandom_range(0, 99) < 7) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.session      <= s;
        in_ch.in_byte      <= b;
        in_ch.end_of_chunk <= 1'($urandom_range(0, 1));
        do @(posedge i_clk); while (!in_ch.ready);
        sent_count++;
    endtask

    task automatic send_str(input logic [1:0] s, input string text);
        for (int i = 0; i < text.len(); i++) send_byte(s, text[i]);
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] specials[10];
        specials = '{CH_ESC, CH_LBRACK, CH_QUEST, CH_TWO, CH_ZERO, CH_SIX,
                     CH_SET, CH_RESET, CH_SAVE, CH_REST};
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
        return specials[$urandom_range(0, 9)];
    endfunction

    // Build one random escape sequence, well formed in half of the picks
    task automatic send_random_sequence();
        logic [7:0] seq[$];
        logic [1:0] s;
        int         pick;
        int         len;
        s    = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            seq = '{CH_ESC, CH_LBRACK, CH_SAVE};
        end else if (pick < 30) begin
            seq = '{CH_ESC, CH_LBRACK, CH_REST};
        end else if (pick < 50) begin
            for (int i = 0; i < 7; i++) seq.push_back(sb.held_prefix[i]);
            seq.push_back($urandom_range(0, 1) ? CH_SET : CH_RESET);
        end else if (pick < 75) begin
            // mostly broken: a prefix of one to seven bytes plus an arbitrary byte
            len = $urandom_range(1, 7);
            for (int i = 0; i < len; i++) seq.push_back(sb.held_prefix[i]);
            seq.push_back(noise_byte());
        end else begin
            seq.push_back(noise_byte());
        end
        foreach (seq[i]) begin
            if ($urandom_range(0, 99) < 15)
                send_byte(2'($urandom_range(0, 3)), noise_byte());
            send_byte(s, seq[i]);
        end
    endtask

    // Main sequence
    initial begin
        int dir_count;
        in_ch.valid        = 1'b0;
        in_ch.session      = '0;
        in_ch.in_byte      = '0;
        in_ch.end_of_chunk = 1'b0;
        i_rst_n            = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: byte extremes, rewrites, drop, replays, lone ESC
        send_byte(0, 8'h00);
        send_byte(3, 8'hFF);
        send_byte(1, CH_ESC);
        send_byte(2, CH_ESC);
        send_byte(1, CH_LBRACK);
        send_byte(2, CH_LBRACK);
        send_byte(1, CH_SAVE);
        send_byte(2, CH_REST);
        send_str(0, "\033[?20");
        send_byte(3, "x");
        send_str(0, "26h");
        send_str(1, "\033[?20267");
        send_str(3, "\033\033[x");
        send_str(0, "\033A");
        dir_count = sent_count;

        // Random: idle-free stretch in the middle, one long output hold-off
        while (sent_count < dir_count + 150) begin
            if (sent_count >= dir_count + 40 && hold_requests == 0) hold_requests++;
            idle_enable = !(sent_count >= dir_count + 70 && sent_count < dir_count + 120);
            send_random_sequence();
        end
        idle_enable = 1'b1;

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop
    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
